[rtl/pbrf_pkg.sv]
`default_nettype none

package pbrf_pkg;

    localparam int STORE_DEPTH = 16384;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int EFF_W       = ADDR_W + 1;
    localparam int RING_W      = 15;
    localparam int RING_RESET  = 16384;
    localparam int MIN_RING    = 8;
    localparam int LEN_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int PAD_W       = 17;
    localparam int CLAMP_W     = (RING_W > EFF_W) ? RING_W : EFF_W;
    localparam int SPACE_W     = (PAD_W + 1 > EFF_W) ? PAD_W + 1 : EFF_W;
    localparam int MOD_VAL_W   = ((ADDR_W > PAD_W) ? ADDR_W : PAD_W) + 1;
    localparam int MOD_STEPS   = MOD_VAL_W - $clog2(MIN_RING);
    localparam int MOD_DIV_W   = EFF_W + MOD_STEPS - 1;
    localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

    localparam logic [1:0] KIND_OPEN_WR = 2'd0;
    localparam logic [1:0] KIND_WR_BYTE = 2'd1;
    localparam logic [1:0] KIND_OPEN_RD = 2'd2;
    localparam logic [1:0] KIND_RD_BYTE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_SEQ   = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [LEN_W-1:0]  packet_length;
        logic [LEN_W-1:0]  capacity;
        logic [BYTE_W-1:0] data_byte;
    } req_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } rsp_item_t;

    function automatic logic [EFF_W-1:0] clamp_ring(input logic [RING_W-1:0] r);
        logic [CLAMP_W-1:0] v;
        v = CLAMP_W'(r);
        if (v < CLAMP_W'(MIN_RING))
        begin
            v = CLAMP_W'(MIN_RING);
        end
        else if (v > CLAMP_W'(STORE_DEPTH))
        begin
            v = CLAMP_W'(STORE_DEPTH);
        end
        return EFF_W'(v);
    endfunction

    function automatic logic [PAD_W-1:0] padded_size(input logic [LEN_W-1:0] len);
        return (PAD_W'(len) + PAD_W'(5)) & ~PAD_W'(3);
    endfunction

    function automatic logic [1:0] pad_of(input logic [1:0] lo);
        return 2'(2'd0 - (lo + 2'd2));
    endfunction

    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] p,
                                                   input logic [1:0] k,
                                                   input logic [EFF_W-1:0] n);
        logic [EFF_W:0] s;
        s = (EFF_W+1)'(p) + (EFF_W+1)'(k);
        if (s >= (EFF_W+1)'(n))
        begin
            s = s - (EFF_W+1)'(n);
        end
        return ADDR_W'(s);
    endfunction

endpackage

`default_nettype wire

[rtl/pbrf_if.sv]
`default_nettype none

interface pbrf_req_if;
    logic                 valid;
    logic                 ready;
    pbrf_pkg::req_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pbrf_rsp_if;
    logic                 valid;
    logic                 ready;
    pbrf_pkg::rsp_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pbrf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pbrf_pkg::RING_W-1:0]   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/packet_byte_ring_fifo.sv]
// Channel  Role    Handshake      Payload
// req      sink    valid/ready    kind, packet_length, capacity, data_byte
// rsp      source  valid/ready    status, length, out_byte, last
// cfg      sink    valid/ready    ring_size (15 bits)
//
// A data byte write stores the byte; after the last byte of a packet the zero pad bytes are stored.
// An open write stores the low, then the high length byte; for a zero-length packet the pad follows at once.
// A read byte is fetched from the store and then returned; a refused, empty or out-of-order item is answered from idle.
// An open read fetches both length bytes, then waits for the remainder unit to give the next tail.
// Reset clears positions and sets ring_size to 16384; the byte store is not cleared.
// One result waits in the output register and one more in a hold register while rsp stalls.
`default_nettype none

module packet_byte_ring_fifo (
    input  logic        clk,
    input  logic        rst_n,
    pbrf_req_if.sink    req,
    pbrf_rsp_if.source  rsp,
    pbrf_cfg_if.sink    cfg
);

    import pbrf_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_WLEN_HI = 3'd1;
    localparam logic [2:0] S_PAD     = 3'd2;
    localparam logic [2:0] S_RLEN0   = 3'd3;
    localparam logic [2:0] S_RLEN1   = 3'd4;
    localparam logic [2:0] S_RMOD    = 3'd5;
    localparam logic [2:0] S_RBYTE   = 3'd6;
    localparam logic [2:0] S_PEND    = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [EFF_W-1:0]  eff_reg, eff_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic              wr_open_reg, wr_open_next;
    logic [ADDR_W-1:0] wr_cursor_reg, wr_cursor_next;
    logic [LEN_W-1:0]  wr_left_reg, wr_left_next;
    logic [1:0]        pad_left_reg, pad_left_next;
    logic              rd_open_reg, rd_open_next;
    logic [ADDR_W-1:0] rd_cursor_reg, rd_cursor_next;
    logic [LEN_W-1:0]  rd_left_reg, rd_left_next;
    logic [ADDR_W-1:0] rd_next_tail_reg, rd_next_tail_next;
    logic              out_valid_reg, out_valid_next;

    logic [LEN_W-1:0]  wlen_reg, wlen_next;
    logic [LEN_W-1:0]  cap_reg, cap_next;
    logic [BYTE_W-1:0] len_lo_reg, len_lo_next;
    logic [LEN_W-1:0]  copy_reg, copy_next;
    rsp_item_t         res_reg, res_next;
    rsp_item_t         out_data_reg, out_data_next;

    logic              mem_en;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [BYTE_W-1:0] mem_wdata;
    logic [BYTE_W-1:0] mem_rdata;

    logic                 mod_start;
    logic [MOD_VAL_W-1:0] mod_value;
    logic                 mod_done;
    logic [ADDR_W-1:0]    mod_rem;

    logic              emit;
    rsp_item_t         emit_item;
    logic              out_can_load;
    logic [EFF_W-1:0]  space;
    logic              wr_full;
    logic [ADDR_W-1:0] wr_cursor_inc;
    logic [ADDR_W-1:0] rd_cursor_inc;
    logic [1:0]        wr_pad;
    logic [LEN_W-1:0]  rd_len;

    pbrf_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (BYTE_W)
    ) u_ram (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    pbrf_mod u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start),
        .value   (mod_value),
        .divisor (eff_reg),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    assign out_can_load  = !out_valid_reg || rsp.ready;
    assign space         = (head_reg >= tail_reg)
                           ? EFF_W'(eff_reg - EFF_W'(head_reg) + EFF_W'(tail_reg))
                           : EFF_W'(EFF_W'(tail_reg) - EFF_W'(head_reg));
    assign wr_full       = (SPACE_W'(padded_size(req.data.packet_length)) + SPACE_W'(1))
                           > SPACE_W'(space);
    assign wr_cursor_inc = wrap_add(wr_cursor_reg, 2'd1, eff_reg);
    assign rd_cursor_inc = wrap_add(rd_cursor_reg, 2'd1, eff_reg);
    assign wr_pad        = pad_of(wlen_reg[1:0]);
    assign rd_len        = {mem_rdata, len_lo_reg};
    assign mod_value     = MOD_VAL_W'(tail_reg) + MOD_VAL_W'(padded_size(rd_len));

    always_comb
    begin
        state_next        = state_reg;
        eff_next          = eff_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        wr_open_next      = wr_open_reg;
        wr_cursor_next    = wr_cursor_reg;
        wr_left_next      = wr_left_reg;
        pad_left_next     = pad_left_reg;
        rd_open_next      = rd_open_reg;
        rd_cursor_next    = rd_cursor_reg;
        rd_left_next      = rd_left_reg;
        rd_next_tail_next = rd_next_tail_reg;
        wlen_next         = wlen_reg;
        cap_next          = cap_reg;
        len_lo_next       = len_lo_reg;
        copy_next         = copy_reg;
        res_next          = res_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_data_next     = out_data_reg;
        mem_en            = 1'b0;
        mem_we            = 1'b0;
        mem_addr          = head_reg;
        mem_wdata         = '0;
        mod_start         = 1'b0;
        emit              = 1'b0;
        emit_item         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg.valid)
                begin
                    eff_next          = clamp_ring(cfg.data);
                    head_next         = '0;
                    tail_next         = '0;
                    wr_open_next      = 1'b0;
                    wr_cursor_next    = '0;
                    wr_left_next      = '0;
                    rd_open_next      = 1'b0;
                    rd_cursor_next    = '0;
                    rd_left_next      = '0;
                    rd_next_tail_next = '0;
                end
                else if (req.valid)
                begin
                    unique case (req.data.kind)
                        KIND_OPEN_WR:
                        begin
                            if (wr_open_reg)
                            begin
                                emit             = 1'b1;
                                emit_item.status = ST_SEQ;
                            end
                            else if (wr_full)
                            begin
                                emit             = 1'b1;
                                emit_item.status = ST_FULL;
                            end
                            else
                            begin
                                mem_en         = 1'b1;
                                mem_we         = 1'b1;
                                mem_addr       = head_reg;
                                mem_wdata      = req.data.packet_length[7:0];
                                wlen_next      = req.data.packet_length;
                                wr_cursor_next = wrap_add(head_reg, 2'd1, eff_reg);
                                state_next     = S_WLEN_HI;
                            end
                        end
                        KIND_WR_BYTE:
                        begin
                            if (!wr_open_reg)
                            begin
                                emit             = 1'b1;
                                emit_item.status = ST_SEQ;
                            end
                            else
                            begin
                                mem_en         = 1'b1;
                                mem_we         = 1'b1;
                                mem_addr       = wr_cursor_reg;
                                mem_wdata      = req.data.data_byte;
                                wr_cursor_next = wr_cursor_inc;
                                wr_left_next   = wr_left_reg - LEN_W'(1);
                                if (wr_left_reg == LEN_W'(1))
                                begin
                                    if (wr_pad == 2'd0)
                                    begin
                                        head_next      = wr_cursor_inc;
                                        wr_open_next   = 1'b0;
                                        emit           = 1'b1;
                                        emit_item.last = 1'b1;
                                    end
                                    else
                                    begin
                                        pad_left_next = wr_pad;
                                        res_next      = '0;
                                        res_next.last = 1'b1;
                                        state_next    = S_PAD;
                                    end
                                end
                                else
                                begin
                                    emit = 1'b1;
                                end
                            end
                        end
                        KIND_OPEN_RD:
                        begin
                            if (rd_open_reg)
                            begin
                                emit             = 1'b1;
                                emit_item.status = ST_SEQ;
                            end
                            else if (head_reg == tail_reg)
                            begin
                                emit             = 1'b1;
                                emit_item.status = ST_EMPTY;
                            end
                            else
                            begin
                                mem_en     = 1'b1;
                                mem_addr   = tail_reg;
                                cap_next   = req.data.capacity;
                                state_next = S_RLEN0;
                            end
                        end
                        KIND_RD_BYTE:
                        begin
                            if (!rd_open_reg)
                            begin
                                emit             = 1'b1;
                                emit_item.status = ST_SEQ;
                            end
                            else
                            begin
                                mem_en     = 1'b1;
                                mem_addr   = rd_cursor_reg;
                                state_next = S_RBYTE;
                            end
                        end
                    endcase
                end
            end
            S_WLEN_HI:
            begin
                mem_en         = 1'b1;
                mem_we         = 1'b1;
                mem_addr       = wr_cursor_reg;
                mem_wdata      = wlen_reg[15:8];
                wr_cursor_next = wr_cursor_inc;
                wr_open_next   = 1'b1;
                wr_left_next   = wlen_reg;
                if (wlen_reg == '0)
                begin
                    pad_left_next = wr_pad;
                    res_next      = '0;
                    res_next.last = 1'b1;
                    state_next    = S_PAD;
                end
                else
                begin
                    emit             = 1'b1;
                    emit_item.length = wlen_reg;
                    state_next       = S_IDLE;
                end
            end
            S_PAD:
            begin
                mem_en         = 1'b1;
                mem_we         = 1'b1;
                mem_addr       = wr_cursor_reg;
                mem_wdata      = '0;
                wr_cursor_next = wr_cursor_inc;
                pad_left_next  = pad_left_reg - 2'd1;
                if (pad_left_reg == 2'd1)
                begin
                    head_next    = wr_cursor_inc;
                    wr_open_next = 1'b0;
                    wr_left_next = '0;
                    emit         = 1'b1;
                    emit_item    = res_reg;
                    state_next   = S_IDLE;
                end
            end
            S_RLEN0:
            begin
                len_lo_next = mem_rdata;
                mem_en      = 1'b1;
                mem_addr    = wrap_add(tail_reg, 2'd1, eff_reg);
                state_next  = S_RLEN1;
            end
            S_RLEN1:
            begin
                mod_start  = 1'b1;
                copy_next  = (rd_len > cap_reg) ? cap_reg : rd_len;
                state_next = S_RMOD;
            end
            S_RMOD:
            begin
                if (mod_done)
                begin
                    rd_next_tail_next = mod_rem;
                    emit              = 1'b1;
                    state_next        = S_IDLE;
                    if (copy_reg == '0)
                    begin
                        tail_next      = mod_rem;
                        emit_item.last = 1'b1;
                    end
                    else
                    begin
                        rd_cursor_next   = wrap_add(tail_reg, 2'd2, eff_reg);
                        rd_left_next     = copy_reg;
                        rd_open_next     = 1'b1;
                        emit_item.length = copy_reg;
                    end
                end
            end
            S_RBYTE:
            begin
                emit               = 1'b1;
                emit_item.out_byte = mem_rdata;
                rd_cursor_next     = rd_cursor_inc;
                rd_left_next       = rd_left_reg - LEN_W'(1);
                if (rd_left_reg == LEN_W'(1))
                begin
                    tail_next      = rd_next_tail_reg;
                    rd_open_next   = 1'b0;
                    emit_item.last = 1'b1;
                end
                state_next = S_IDLE;
            end
            S_PEND:
            begin
                emit       = 1'b1;
                emit_item  = res_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A result that finds the output register busy is parked in the hold register.
        if (emit)
        begin
            if (out_can_load)
            begin
                out_valid_next = 1'b1;
                out_data_next  = emit_item;
            end
            else
            begin
                res_next   = emit_item;
                state_next = S_PEND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            eff_reg          <= clamp_ring(RING_W'(RING_RESET));
            head_reg         <= '0;
            tail_reg         <= '0;
            wr_open_reg      <= 1'b0;
            wr_cursor_reg    <= '0;
            wr_left_reg      <= '0;
            pad_left_reg     <= '0;
            rd_open_reg      <= 1'b0;
            rd_cursor_reg    <= '0;
            rd_left_reg      <= '0;
            rd_next_tail_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            eff_reg          <= eff_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            wr_open_reg      <= wr_open_next;
            wr_cursor_reg    <= wr_cursor_next;
            wr_left_reg      <= wr_left_next;
            pad_left_reg     <= pad_left_next;
            rd_open_reg      <= rd_open_next;
            rd_cursor_reg    <= rd_cursor_next;
            rd_left_reg      <= rd_left_next;
            rd_next_tail_reg <= rd_next_tail_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wlen_reg     <= wlen_next;
        cap_reg      <= cap_next;
        len_lo_reg   <= len_lo_next;
        copy_reg     <= copy_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign req.ready = (state_reg == S_IDLE) && !cfg.valid;
    assign cfg.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule

`default_nettype wire

[rtl/pbrf_ram.sv]
`default_nettype none

module pbrf_ram #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

[rtl/pbrf_mod.sv]
`default_nettype none

module pbrf_mod (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [pbrf_pkg::MOD_VAL_W-1:0] value,
    input  logic [pbrf_pkg::EFF_W-1:0]     divisor,
    output logic                           done,
    output logic [pbrf_pkg::ADDR_W-1:0]    rem
);

    import pbrf_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [MOD_VAL_W-1:0] rem_reg, rem_next;
    logic [MOD_DIV_W-1:0] div_reg, div_next;

    // One quotient bit per cycle: subtract the divisor shifted down by one place each step.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = MOD_CNT_W'(MOD_STEPS - 1);
            rem_next  = value;
            div_next  = MOD_DIV_W'(divisor) << (MOD_STEPS - 1);
        end
        else if (busy_reg)
        begin
            if (MOD_DIV_W'(rem_reg) >= div_reg)
            begin
                rem_next = MOD_VAL_W'(MOD_DIV_W'(rem_reg) - div_reg);
            end
            div_next = div_reg >> 1;
            cnt_next = cnt_reg - MOD_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = ADDR_W'(rem_reg);

endmodule

`default_nettype wire
